// ===== sv/rc4_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants for the RC4 stream cipher block.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned KEY_LEN_W = 9;
  localparam int unsigned PERM_SIZE = 256;

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [KEY_LEN_W-1:0] key_len_t;
  typedef logic [1:0]           cmd_t;

  localparam cmd_t CMD_LOAD  = 2'd0;
  localparam cmd_t CMD_SCHED = 2'd1;
  localparam cmd_t CMD_CRYPT = 2'd2;

  // key index counter control
  typedef struct packed {
    logic clear;
    logic step;
  } kctr_ctl_t;

endpackage

// ===== sv/rc4_key_ctr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_key_ctr
// Key store index for the key schedule: counts modulo the effective key length.
// ----------------------------------------------------------------------------
module rc4_key_ctr #(
  parameter int KEY_DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rc4_pkg::key_len_t        key_length,
  input  rc4_pkg::kctr_ctl_t       ctl,
  output logic [$clog2(KEY_DEPTH)-1:0] idx
);

  localparam int KW = $clog2(KEY_DEPTH);

  rc4_pkg::key_len_t eff_len;
  logic              wrap;
  logic [KW-1:0]     idx_r;
  logic [KW-1:0]     idx_nxt;

  // zero counts as one, anything past the store saturates
  always_comb begin
    if (key_length == '0) begin
      eff_len = rc4_pkg::KEY_LEN_W'(1);
    end else if (key_length > rc4_pkg::KEY_LEN_W'(KEY_DEPTH)) begin
      eff_len = rc4_pkg::KEY_LEN_W'(KEY_DEPTH);
    end else begin
      eff_len = key_length;
    end
  end

  assign wrap = ((rc4_pkg::KEY_LEN_W'(idx_r) + rc4_pkg::KEY_LEN_W'(1)) == eff_len);

  always_comb begin
    idx_nxt = idx_r;
    if (ctl.clear) begin
      idx_nxt = '0;
    end else if (ctl.step) begin
      idx_nxt = wrap ? '0 : idx_r + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  assign idx = idx_r;

endmodule

// ===== sv/rc4_stream_cipher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 byte cipher with key store, key scheduler and keystream generator.
// ----------------------------------------------------------------------------
// Usage: load key bytes with cmd 0 (one per request, at key_index), set
// key_length on the cfg port while idle, then send cmd 1 to run the key
// schedule. Each cmd 2 request then XORs its byte with the next keystream
// byte and returns one result; before any schedule the byte passes through
// with keystream 0 and not_keyed set. Loads and schedules return nothing,
// cmd 3 is ignored. All permutation traffic goes through one RAM with one
// write and one registered read per cycle, and that port sets the pace:
// a schedule fills the identity, then for 256 steps reads S[k], forms j
// and reads S[j], writes S[k], writes S[j]; a keyed crypt steps i, reads
// S[i] and S[j], swaps them and reads S[S[i]+S[j]]. A finished result sits
// in the output register, so the next request is taken even while the
// consumer stalls; a crypt only waits at its end if that register is full.
// ----------------------------------------------------------------------------
module rc4_stream_cipher #(
  parameter int KEY_DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // request channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  rc4_pkg::cmd_t            in_cmd,
  input  rc4_pkg::byte_t           in_key_index,
  input  rc4_pkg::byte_t           in_byte_value,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output rc4_pkg::byte_t           out_byte,
  output rc4_pkg::byte_t           out_keystream,
  output logic                     out_not_keyed,
  // key length register
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  rc4_pkg::key_len_t        cfg_data
);

  localparam int KW = $clog2(KEY_DEPTH);

  // sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_FILL   = 4'd1;  // identity fill, one entry a cycle
  localparam logic [3:0] ST_KSA_RD = 4'd2;  // read S[k]
  localparam logic [3:0] ST_KSA_J  = 4'd3;  // new j, read S[j]
  localparam logic [3:0] ST_KSA_WK = 4'd4;  // S[k] = S[j]
  localparam logic [3:0] ST_KSA_WJ = 4'd5;  // S[j] = old S[k]
  localparam logic [3:0] ST_PR_RI  = 4'd6;  // i++, read S[i]
  localparam logic [3:0] ST_PR_RJ  = 4'd7;  // j += S[i], read S[j]
  localparam logic [3:0] ST_PR_WI  = 4'd8;  // S[i] = S[j]
  localparam logic [3:0] ST_PR_WJ  = 4'd9;  // S[j] = S[i], read S[S[i]+S[j]]
  localparam logic [3:0] ST_PR_KS  = 4'd10; // pick keystream byte
  localparam logic [3:0] ST_DONE   = 4'd11; // hand result to output register

  localparam rc4_pkg::byte_t LAST_IDX = rc4_pkg::BYTE_W'(rc4_pkg::PERM_SIZE - 1);

  // control registers
  logic [3:0]         state_r, state_nxt;
  rc4_pkg::byte_t     i_r, i_nxt;
  rc4_pkg::byte_t     j_r, j_nxt;
  rc4_pkg::byte_t     k_r, k_nxt;
  logic               keyed_r, keyed_nxt;
  rc4_pkg::key_len_t  key_len_r;
  logic               out_valid_r, out_valid_nxt;

  // payload registers
  rc4_pkg::byte_t     si_r, si_nxt;
  rc4_pkg::byte_t     sj_r, sj_nxt;
  rc4_pkg::byte_t     byte_r, byte_nxt;
  rc4_pkg::byte_t     ks_r, ks_nxt;
  logic               nk_r, nk_nxt;
  logic               hit_r, hit_nxt;
  rc4_pkg::byte_t     out_byte_r;
  rc4_pkg::byte_t     out_ks_r;
  logic               out_nk_r;

  // permutation RAM port
  rc4_pkg::byte_t     perm_mem [rc4_pkg::PERM_SIZE];
  logic               s_we;
  rc4_pkg::byte_t     s_waddr;
  rc4_pkg::byte_t     s_wdata;
  rc4_pkg::byte_t     s_raddr;
  rc4_pkg::byte_t     s_rd_r;

  // key store
  rc4_pkg::byte_t     key_mem [KEY_DEPTH];
  logic               key_we;
  logic [KW-1:0]      key_raddr;
  rc4_pkg::byte_t     key_rd_r;

  rc4_pkg::kctr_ctl_t kctl;

  logic               in_acc;
  logic               out_free;
  logic               load_out;
  rc4_pkg::byte_t     sum_b;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign load_out  = (state_r == ST_DONE) && out_free;
  assign cfg_ready = 1'b1;

  assign key_we = in_acc && (in_cmd == rc4_pkg::CMD_LOAD) &&
                  ({1'b0, in_key_index} < rc4_pkg::KEY_LEN_W'(KEY_DEPTH));

  rc4_key_ctr #(
    .KEY_DEPTH (KEY_DEPTH)
  ) u_key_ctr (
    .clk        (clk),
    .rst_n      (rst_n),
    .key_length (key_len_r),
    .ctl        (kctl),
    .idx        (key_raddr)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    keyed_nxt = keyed_r;
    si_nxt    = si_r;
    sj_nxt    = sj_r;
    byte_nxt  = byte_r;
    ks_nxt    = ks_r;
    nk_nxt    = nk_r;
    hit_nxt   = hit_r;
    s_we      = 1'b0;
    s_waddr   = '0;
    s_wdata   = '0;
    s_raddr   = '0;
    sum_b     = '0;
    kctl      = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            rc4_pkg::CMD_SCHED: begin
              k_nxt      = '0;
              j_nxt      = '0;
              kctl.clear = 1'b1;
              state_nxt  = ST_FILL;
            end
            rc4_pkg::CMD_CRYPT: begin
              byte_nxt = in_byte_value;
              if (keyed_r) begin
                nk_nxt    = 1'b0;
                state_nxt = ST_PR_RI;
              end else begin
                ks_nxt    = '0;
                nk_nxt    = 1'b1;
                state_nxt = ST_DONE;
              end
            end
            default: begin
              // key loads write the store directly; unused code does nothing
            end
          endcase
        end
      end
      ST_FILL: begin
        s_we    = 1'b1;
        s_waddr = k_r;
        s_wdata = k_r;
        k_nxt   = k_r + 8'd1;
        if (k_r == LAST_IDX) begin
          state_nxt = ST_KSA_RD;
        end
      end
      ST_KSA_RD: begin
        s_raddr   = k_r;
        state_nxt = ST_KSA_J;
      end
      ST_KSA_J: begin
        sum_b     = j_r + s_rd_r + key_rd_r;
        s_raddr   = sum_b;
        j_nxt     = sum_b;
        si_nxt    = s_rd_r;
        state_nxt = ST_KSA_WK;
      end
      ST_KSA_WK: begin
        s_we      = 1'b1;
        s_waddr   = k_r;
        s_wdata   = s_rd_r;
        state_nxt = ST_KSA_WJ;
      end
      ST_KSA_WJ: begin
        s_we      = 1'b1;
        s_waddr   = j_r;
        s_wdata   = si_r;
        k_nxt     = k_r + 8'd1;
        kctl.step = 1'b1;
        if (k_r == LAST_IDX) begin
          i_nxt     = '0;
          j_nxt     = '0;
          keyed_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_KSA_RD;
        end
      end
      ST_PR_RI: begin
        i_nxt     = i_r + 8'd1;
        s_raddr   = i_r + 8'd1;
        state_nxt = ST_PR_RJ;
      end
      ST_PR_RJ: begin
        sum_b     = j_r + s_rd_r;
        s_raddr   = sum_b;
        j_nxt     = sum_b;
        si_nxt    = s_rd_r;
        state_nxt = ST_PR_WI;
      end
      ST_PR_WI: begin
        s_we      = 1'b1;
        s_waddr   = i_r;
        s_wdata   = s_rd_r;
        sj_nxt    = s_rd_r;
        state_nxt = ST_PR_WJ;
      end
      ST_PR_WJ: begin
        // read happens alongside the S[j] write; bypass when they collide
        s_we      = 1'b1;
        s_waddr   = j_r;
        s_wdata   = si_r;
        sum_b     = si_r + sj_r;
        s_raddr   = sum_b;
        hit_nxt   = (sum_b == j_r);
        state_nxt = ST_PR_KS;
      end
      ST_PR_KS: begin
        ks_nxt    = hit_r ? si_r : s_rd_r;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      keyed_r     <= 1'b0;
      key_len_r   <= rc4_pkg::KEY_LEN_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      keyed_r     <= keyed_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        key_len_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    si_r   <= si_nxt;
    sj_r   <= sj_nxt;
    byte_r <= byte_nxt;
    ks_r   <= ks_nxt;
    nk_r   <= nk_nxt;
    hit_r  <= hit_nxt;
    if (load_out) begin
      out_byte_r <= byte_r ^ ks_r;
      out_ks_r   <= ks_r;
      out_nk_r   <= nk_r;
    end
  end

  // permutation RAM: one write, one registered read
  always_ff @(posedge clk) begin
    if (s_we) begin
      perm_mem[s_waddr] <= s_wdata;
    end
    s_rd_r <= perm_mem[s_raddr];
  end

  // key store RAM
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[in_key_index[KW-1:0]] <= in_byte_value;
    end
    key_rd_r <= key_mem[key_raddr];
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_keystream = out_ks_r;
  assign out_not_keyed = out_nk_r;

endmodule
